// ----- rtl/core/rxs_pkg.sv -----
package rxs_pkg;

	// Width of one stored record and of the stream data words.
	localparam int REC_W = 56;

	// Sort modes held in the configuration register.
	localparam logic [1:0] MODE_INPUT      = 2'd0;
	localparam logic [1:0] MODE_BYTE       = 2'd1;
	localparam logic [1:0] MODE_PRICE      = 2'd2;
	localparam logic [1:0] MODE_BYTE_PRICE = 2'd3;

	// One record; the tag sits in the lowest bits, as on the stream buses.
	typedef struct packed {
		logic signed [31:0] price;
		logic [7:0]         title;
		logic [15:0]        tag;
	} rec_t;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_LOAD    = 7'b0000010,
		ST_LOADW   = 7'b0000100,
		ST_SCAN    = 7'b0001000,
		ST_FLUSH   = 7'b0010000,
		ST_EMIT_RD = 7'b0100000,
		ST_EMIT_LD = 7'b1000000
	} state_t;

	// Strict ordering test used by the exchange step.
	function automatic logic key_greater(rec_t a, rec_t b, logic by_price);
		logic gt;
		if (by_price) begin
			gt = (a.price > b.price);
		end else begin
			gt = (a.title > b.title);
		end
		return gt;
	endfunction

endpackage

// ----- rtl/core/rxs_ram.sv -----
module rxs_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/record_exchange_sorter.sv -----
// Records are taken one a cycle while the sorter is idle; the store is a single RAM.
// After the item marked last, each exchange pass does one compare a cycle on the RAM read port
// while it scans; mode 3 runs two passes and mode 0 runs none.
// Results then leave one at a time through the output register, each read from the RAM when it is free.
// Reset (arst_n low, asynchronous) empties the set, clears the overflow mark and the sort mode.
// The store itself is not cleared; only entries written in the current set are read.
module record_exchange_sorter #(
	parameter int MAX_RECORDS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration: sort mode.
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_wdata,
	// Input records.
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// record_tag[15:0], title_first_byte[23:16], price_cents[55:24]
	input  logic [rxs_pkg::REC_W-1:0] s_axis_tdata,
	input  logic                     s_axis_tlast,
	// Sorted records.
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// out_tag[15:0], out_title_byte[23:16], out_price_cents[55:24]
	output logic [rxs_pkg::REC_W-1:0] m_axis_tdata,
	output logic                     m_axis_tlast,
	// overflowed[0]
	output logic                     m_axis_tuser
);

	import rxs_pkg::*;

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic           ovf_q;
	logic [1:0]     mode_q;
	logic [AW-1:0]  last_idx_q;
	logic [AW-1:0]  m_q;
	logic [AW-1:0]  n_q;
	rec_t           cur_q;
	logic           price_pass_q;

	logic           out_valid_q;
	rec_t           out_rec_q;
	logic           out_last_q;
	logic           out_ovf_q;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	rec_t           ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	rec_t           ram_rdata;
	logic [REC_W-1:0] ram_rdata_raw;

	rec_t           in_rec;
	logic           in_accept;
	logic           has_room;
	logic           swap;
	logic           out_free;

	assign in_rec        = rec_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign has_room      = (count_q < CW'(MAX_RECORDS));
	assign ram_rdata     = rec_t'(ram_rdata_raw);
	assign swap          = key_greater(cur_q, ram_rdata, price_pass_q);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_rec_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

	// The sort mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INPUT;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// RAM port control for each state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = in_rec;
		ram_re    = 1'b0;
		ram_raddr = m_q;
		case (state_q)
			ST_IDLE: begin
				ram_we = in_accept && has_room;
			end
			ST_LOAD: begin
				ram_re = (m_q != last_idx_q);
			end
			ST_LOADW: begin
				ram_re    = 1'b1;
				ram_raddr = m_q + AW'(1);
			end
			ST_SCAN: begin
				// The current holder moves to the scanned slot when it is larger.
				ram_we    = swap;
				ram_waddr = n_q;
				ram_wdata = cur_q;
				ram_re    = (n_q != last_idx_q);
				ram_raddr = n_q + AW'(1);
			end
			ST_FLUSH: begin
				ram_we    = 1'b1;
				ram_waddr = m_q;
				ram_wdata = cur_q;
			end
			ST_EMIT_RD: begin
				ram_re = out_free;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: collect, sort pass by pass (no pass in input-order mode), then emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			last_idx_q   <= '0;
			m_q          <= '0;
			n_q          <= '0;
			price_pass_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							last_idx_q <= has_room ? count_q[AW-1:0] : AW'(MAX_RECORDS - 1);
							m_q        <= '0;
							case (mode_q)
								MODE_INPUT: begin
									state_q <= ST_EMIT_RD;
								end
								MODE_PRICE: begin
									price_pass_q <= 1'b1;
									state_q      <= ST_LOAD;
								end
								default: begin
									price_pass_q <= 1'b0;
									state_q      <= ST_LOAD;
								end
							endcase
						end
					end
				end
				ST_LOAD: begin
					if (m_q == last_idx_q) begin
						// End of a pass: a byte pass in mode 3 is followed by a price pass.
						m_q <= '0;
						if (!price_pass_q && (mode_q == MODE_BYTE_PRICE)) begin
							price_pass_q <= 1'b1;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end else begin
						state_q <= ST_LOADW;
					end
				end
				ST_LOADW: begin
					n_q     <= m_q + AW'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (n_q == last_idx_q) begin
						state_q <= ST_FLUSH;
					end else begin
						n_q <= n_q + AW'(1);
					end
				end
				ST_FLUSH: begin
					m_q     <= m_q + AW'(1);
					state_q <= ST_LOAD;
				end
				ST_EMIT_RD: begin
					if (out_free) begin
						state_q <= ST_EMIT_LD;
					end
				end
				ST_EMIT_LD: begin
					if (m_q == last_idx_q) begin
						// The set is out; the store is free for the next one.
						m_q     <= '0;
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						m_q     <= m_q + AW'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The record held at position m during its exchange pass.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOADW) begin
			cur_q <= ram_rdata;
		end else if ((state_q == ST_SCAN) && swap) begin
			cur_q <= ram_rdata;
		end
	end

	// Output register: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT_LD) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_rec_q  <= ram_rdata;
			out_last_q <= (m_q == last_idx_q);
			out_ovf_q  <= ovf_q;
		end
	end

	rxs_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_RECORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	// The store is never written while results are being read out.
	a_no_write_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT_RD) || (state_q == ST_EMIT_LD)) |-> !ram_we)
		else $error("store written during emit");

	// A scan write never lands on the entry being read in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("store read and write to one entry");

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECORDS))
		else $error("record count beyond capacity");

	// A scanned entry always lies beyond the held position.
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((n_q > m_q) && (n_q <= last_idx_q)))
		else $error("scan index out of range");

	// A result is only loaded into an empty output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD) |-> !out_valid_q)
		else $error("output register overwritten");

endmodule

// ----- tb/sv/sorted_stream_checker.sv -----
// Watches both record streams and the mode register, works out the sorted order of every
// closed set and compares each emitted item with the oldest expected one.
module sorted_stream_checker #(
	parameter int CAPACITY = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_wdata,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [rxs_pkg::REC_W-1:0] s_axis_tdata,
	input  logic                      s_axis_tlast,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [rxs_pkg::REC_W-1:0] m_axis_tdata,
	input  logic                      m_axis_tlast,
	input  logic                      m_axis_tuser,
	input  logic                      check_done,
	output int                        failures,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		rxs_pkg::rec_t rec;
		logic          last;
		logic          dropped;
	} sorted_item_t;

	logic [1:0]    sort_mode;
	rxs_pkg::rec_t open_set[$];
	logic          open_dropped;
	rxs_pkg::rec_t sort_buf[CAPACITY];
	sorted_item_t  sorted_q[$];
	int            fail_count = 0;
	int            result_no = 0;
	logic          leftover_done = 1'b0;

	assign failures = fail_count;

	// Prints one line for a mismatch and counts it.
	task automatic report(input string msg);
		fail_count++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Strict ordering test, either on the signed price or on the unsigned title byte.
	function automatic bit ranks_above(rxs_pkg::rec_t a, rxs_pkg::rec_t b, bit by_price);
		if (by_price) begin
			return $signed(a.price) > $signed(b.price);
		end
		return a.title > b.title;
	endfunction

	// One exchange pass: every later entry is compared with position m and swapped in when
	// strictly smaller, which also fixes the order of equal keys.
	task exchange_pass(input int cnt, input bit by_price);
		rxs_pkg::rec_t held;
		for (int m = 0; m < cnt; m++) begin
			for (int n = m; n < cnt; n++) begin
				if (ranks_above(sort_buf[m], sort_buf[n], by_price)) begin
					held = sort_buf[m];
					sort_buf[m] = sort_buf[n];
					sort_buf[n] = held;
				end
			end
		end
	endtask

	// Sorts the closed set under the current mode and queues one expected item per record.
	task close_set();
		int           cnt;
		sorted_item_t item;
		cnt = open_set.size();
		for (int i = 0; i < cnt; i++) begin
			sort_buf[i] = open_set[i];
		end
		if (sort_mode == rxs_pkg::MODE_BYTE || sort_mode == rxs_pkg::MODE_BYTE_PRICE) begin
			exchange_pass(cnt, 1'b0);
		end
		if (sort_mode == rxs_pkg::MODE_PRICE || sort_mode == rxs_pkg::MODE_BYTE_PRICE) begin
			exchange_pass(cnt, 1'b1);
		end
		for (int i = 0; i < cnt; i++) begin
			item.rec = sort_buf[i];
			item.last = (i == cnt - 1);
			item.dropped = open_dropped;
			sorted_q.push_back(item);
		end
		open_set.delete();
		open_dropped = 1'b0;
	endtask

	// Stores an accepted record, or marks the set as overflowed once the store is full.
	task take_record(input rxs_pkg::rec_t rec, input logic last);
		if (open_set.size() < CAPACITY) begin
			open_set.push_back(rec);
		end else begin
			open_dropped = 1'b1;
		end
		if (last) begin
			close_set();
		end
	endtask

	// Compares an emitted item with the oldest expected one, field by field.
	task check_result();
		rxs_pkg::rec_t got;
		sorted_item_t  want;
		got = m_axis_tdata;
		if (sorted_q.size() == 0) begin
			report($sformatf("item %0d arrived with nothing expected, tag %h", result_no,
				got.tag));
		end else begin
			want = sorted_q.pop_front();
			if (got.tag !== want.rec.tag || got.title !== want.rec.title ||
			    got.price !== want.rec.price || m_axis_tlast !== want.last ||
			    m_axis_tuser !== want.dropped) begin
				report($sformatf(
					"item %0d: tag %h/%h title %h/%h price %h/%h last %b/%b ovf %b/%b",
					result_no, got.tag, want.rec.tag, got.title, want.rec.title,
					got.price, want.rec.price, m_axis_tlast, want.last,
					m_axis_tuser, want.dropped));
			end
		end
		result_no++;
	endtask

	// Output items are checked before the input of the same edge is taken, so expectations
	// from an earlier set are always served first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode <= rxs_pkg::MODE_INPUT;
			open_set.delete();
			open_dropped = 1'b0;
			sorted_q.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			if (s_axis_tvalid && s_axis_tready) begin
				take_record(s_axis_tdata, s_axis_tlast);
			end
			if (cfg_we) begin
				sort_mode <= cfg_wdata;
			end
			if (check_done && !leftover_done) begin
				leftover_done <= 1'b1;
				if (sorted_q.size() != 0) begin
					report($sformatf("%0d expected items never arrived", sorted_q.size()));
				end
			end
			pending <= sorted_q.size();
		end
	end

endmodule

// ----- tb/sv/record_exchange_sorter_tb.sv -----
// Drives sets of records into the sorter under all sort modes and gives the verdict.
module record_exchange_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 64;
	localparam int RANDOM_ITEMS = 410;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [1:0]                cfg_wdata;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [rxs_pkg::REC_W-1:0] s_axis_tdata;
	logic                      s_axis_tlast;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [rxs_pkg::REC_W-1:0] m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      m_axis_tuser;
	logic                      check_done;
	int                        failures;
	int                        pending;

	rxs_pkg::rec_t batch[$];
	int            burst_left = 0;
	logic [15:0]   ready_pattern = 16'hFFFF;
	int unsigned   pattern_pos = 0;

	record_exchange_sorter #(
		.MAX_RECORDS(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	sorted_stream_checker #(
		.CAPACITY(CAPACITY)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.check_done(check_done),
		.failures(failures),
		.pending(pending)
	);

	// Clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver follows a 16-bit ready pattern that is redrawn each time the low six bits of
	// the position counter are zero; some patterns are all ones, giving stretches without stalls.
	always @(posedge clk) begin
		if (pattern_pos[5:0] == 6'd0) begin
			ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF :
				(16'($urandom()) | 16'h0001);
		end
		m_axis_tready <= ready_pattern[pattern_pos[3:0]];
		pattern_pos <= pattern_pos + 1;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Waits until every expected item has come out and the sorter has settled back to idle.
	// The count of expected items is a registered copy of the checker's queue size.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Writes the sort mode while the sorter is idle.
	task automatic load_mode(input logic [1:0] mode);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one record; bursts of random length are separated by random gaps, some of them empty.
	task automatic send_record(input rxs_pkg::rec_t rec, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rec;
		s_axis_tlast <= last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		burst_left--;
	endtask

	// Sends the queued records as one set, the final one marked last.
	task automatic send_batch();
		for (int i = 0; i < batch.size(); i++) begin
			send_record(batch[i], i == batch.size() - 1);
		end
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		batch.delete();
	endtask

	task automatic add(input logic [15:0] tag, input logic [7:0] title,
	                   input logic [31:0] price);
		rxs_pkg::rec_t rec;
		rec.tag = tag;
		rec.title = title;
		rec.price = price;
		batch.push_back(rec);
	endtask

	// Random record; narrow ranges for the keys make equal keys common.
	function automatic rxs_pkg::rec_t random_record();
		rxs_pkg::rec_t rec;
		rec.tag = 16'($urandom());
		rec.title = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) :
			8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: begin
				rec.price = $urandom_range(0, 6) - 3;
			end
			1: begin
				case ($urandom_range(0, 3))
					0: rec.price = 32'h8000_0000;
					1: rec.price = 32'h7FFF_FFFF;
					2: rec.price = 32'hFFFF_FFFF;
					default: rec.price = 32'h0000_0000;
				endcase
			end
			default: begin
				rec.price = $urandom();
			end
		endcase
		return rec;
	endfunction

	initial begin
		int sent;
		int set_no;
		int set_size;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= rxs_pkg::MODE_INPUT;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		check_done <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Input order: a single-record set with every field at its top, then a set led by the bottoms.
		load_mode(rxs_pkg::MODE_INPUT);
		add(16'hFFFF, 8'hFF, 32'h7FFF_FFFF);
		send_batch();
		add(16'h0000, 8'h00, 32'h8000_0000);
		add(16'h0001, 8'hFF, 32'h0000_0000);
		add(16'h0002, 8'h00, 32'hFFFF_FFFF);
		send_batch();

		// Title byte order, with equal bytes to expose the tie order.
		load_mode(rxs_pkg::MODE_BYTE);
		add(16'h0010, 8'hFF, 32'h0000_0001);
		add(16'h0011, 8'h07, 32'h0000_0002);
		add(16'h0012, 8'h00, 32'h0000_0003);
		add(16'h0013, 8'h07, 32'h0000_0004);
		add(16'h0014, 8'h80, 32'h0000_0005);
		send_batch();

		// Signed price order across both extremes and around zero.
		load_mode(rxs_pkg::MODE_PRICE);
		add(16'h0020, 8'h01, 32'h7FFF_FFFF);
		add(16'h0021, 8'h02, 32'h8000_0000);
		add(16'h0022, 8'h03, 32'hFFFF_FFFF);
		add(16'h0023, 8'h04, 32'h0000_0000);
		add(16'h0024, 8'h05, 32'h0000_0001);
		add(16'h0025, 8'h06, 32'hFFFF_FFFF);
		send_batch();

		// Byte pass followed by a price pass on its result.
		load_mode(rxs_pkg::MODE_BYTE_PRICE);
		add(16'h0030, 8'h02, 32'h0000_0005);
		add(16'h0031, 8'h01, 32'hFFFF_FFFB);
		add(16'h0032, 8'h02, 32'hFFFF_FFFB);
		add(16'h0033, 8'h01, 32'h0000_0005);
		add(16'h0034, 8'h01, 32'h0000_0000);
		send_batch();

		// Random sets, mostly small; a full store, and two sets that overflow it, both of
		// them losing the record marked last.
		sent = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if (set_no == 4) begin
				set_size = CAPACITY;
			end else if (set_no == 9) begin
				set_size = CAPACITY + 2;
			end else if (set_no == 14) begin
				set_size = CAPACITY + 6;
			end else begin
				set_size = $urandom_range(1, 12);
			end
			if ($urandom_range(0, 1) == 0) begin
				load_mode(2'($urandom_range(0, 3)));
			end
			for (int i = 0; i < set_size; i++) begin
				batch.push_back(random_record());
			end
			send_batch();
			sent += set_size;
			set_no++;
		end

		// Let the last set drain, then ask for left-over expectations and give the verdict.
		wait_drained();
		repeat (20) @(posedge clk);
		check_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
